@@ rtl/rlpde_pkg.sv @@
package rlpde_pkg;

   localparam int PIXEL_SLOTS = 24;
   localparam int CHAN_WIDTH = 8;
   localparam int CSR_ADDR_WIDTH = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
   localparam logic [1:0] REG_HIGH_DUTY = 2'd1;
   localparam logic [1:0] REG_LOW_DUTY = 2'd2;

   localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;
   localparam logic [15:0] HIGH_DUTY_RESET = 16'd60;
   localparam logic [15:0] LOW_DUTY_RESET = 16'd30;

   // Item opcodes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_END_FRAME = 1'b1;

   // One item as it travels from the front to the back, channels already scaled.
   typedef struct packed {
      logic       opcode;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
   } item_type;

   // floor(p / 255) for p < 65280, by the reciprocal form (p + (p >> 8) + 1) >> 8.
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] sum;
      sum = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

@@ rtl/rlpde_front.sv @@
module rlpde_front
   import rlpde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_opcode,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] brightness,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   logic        valid_ff, valid_in;
   logic        opcode_ff;
   logic [15:0] red_prod_ff, green_prod_ff, blue_prod_ff;
   logic        accept;

   // The product stage holds its item while the queue is full.
   assign busy = valid_ff & q_full;
   assign accept = start & ~busy;
   assign q_push = valid_ff & ~q_full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= req_opcode;
         red_prod_ff <= {8'd0, req_red} * {8'd0, brightness};
         green_prod_ff <= {8'd0, req_green} * {8'd0, brightness};
         blue_prod_ff <= {8'd0, req_blue} * {8'd0, brightness};
      end
   end

   always_comb begin
      q_item.opcode = opcode_ff;
      q_item.green = div255(green_prod_ff);
      q_item.red = div255(red_prod_ff);
      q_item.blue = div255(blue_prod_ff);
   end

endmodule

@@ rtl/rlpde_queue.sv @@
module rlpde_queue
   import rlpde_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/rlpde_back.sv @@
module rlpde_back
   import rlpde_pkg::*;
#(
   parameter int RESET_SLOTS = 45,
   parameter int DUTY_WIDTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   input  logic [15:0] high_duty,
   input  logic [15:0] low_duty,
   output logic        rsp_valid,
   output logic [15:0] rsp_duty,
   output logic        rsp_run_end
);

   localparam int MaxSlots = (RESET_SLOTS > PIXEL_SLOTS) ? RESET_SLOTS : PIXEL_SLOTS;
   localparam int CntWidth = $clog2(MaxSlots);
   localparam logic [CntWidth-1:0] PixelLast = CntWidth'(PIXEL_SLOTS - 1);
   localparam logic [CntWidth-1:0] GapLast = CntWidth'(RESET_SLOTS - 1);
   localparam logic [15:0] DutyMask =
      (DUTY_WIDTH >= 16) ? 16'hFFFF : 16'((64'd1 << DUTY_WIDTH) - 64'd1);

   logic                active_ff, active_in;
   logic                opcode_ff, opcode_in;
   logic [CntWidth-1:0] remain_ff, remain_in;
   logic [23:0]         bits_ff, bits_in;
   logic                valid_ff, valid_in;
   logic [15:0]         duty_ff, duty_in;
   logic                run_end_ff, run_end_in;
   logic                last_slot;

   assign last_slot = active_ff & (remain_ff == '0);
   assign pop = head_valid & (~active_ff | last_slot);

   always_comb begin
      active_in = active_ff;
      opcode_in = opcode_ff;
      remain_in = remain_ff;
      bits_in = bits_ff;
      valid_in = active_ff;
      run_end_in = last_slot;
      duty_in = '0;

      if (active_ff && opcode_ff == OP_PIXEL) begin
         duty_in = (bits_ff[23] ? high_duty : low_duty) & DutyMask;
      end

      if (active_ff) begin
         bits_in = {bits_ff[22:0], 1'b0};
         remain_in = remain_ff - CntWidth'(1);
         if (last_slot) begin
            active_in = 1'b0;
         end
      end

      // A queued item starts on the cycle after the previous run's last slot.
      if (pop) begin
         active_in = 1'b1;
         opcode_in = head_item.opcode;
         bits_in = {head_item.green, head_item.red, head_item.blue};
         remain_in = (head_item.opcode == OP_END_FRAME) ? GapLast : PixelLast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      remain_ff <= remain_in;
      bits_ff <= bits_in;
      duty_ff <= duty_in;
      run_end_ff <= run_end_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_duty = duty_ff;
   assign rsp_run_end = run_end_ff;

endmodule

@@ rtl/rgb_led_pwm_duty_encoder_top.sv @@
// RGB LED bit-slot duty encoder.
// Input: an item is taken at a clock edge where start is high and busy is low.
// A pixel item (req_opcode low) carries red, green and blue bytes; each is scaled
// by the brightness register as floor(c * brightness / 255). An end-of-frame item
// (req_opcode high) ignores the color bytes.
// Output: rsp_valid marks one result per cycle. A pixel gives 24 duty values,
// green, red, blue, MSB first, high_duty for a one and low_duty for a zero. An
// end-of-frame item gives RESET_SLOTS zero duties. rsp_run_end marks the last
// result of each item. The receiver cannot stall; results are never held off.
// An item taken passes the product register, the queue and the serializer, and
// each result is registered at the output. The serializer sends one duty value
// per cycle; consecutive queued items produce an unbroken result stream.
// A product stage and a two-entry queue sit ahead of the serializer, so up to
// three items may be waiting; busy rises when all of them are occupied.
// Registers (APB, byte address 4*i): brightness, high_duty, low_duty. Write them
// only while no item is in flight. Reset restores 255, 60 and 30 and empties
// the pipeline.
module rgb_led_pwm_duty_encoder_top
   import rlpde_pkg::*;
#(
   parameter int RESET_SLOTS = 45,
   parameter int DUTY_WIDTH = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_opcode,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      rsp_valid,
   output logic [15:0]               rsp_duty,
   output logic                      rsp_run_end,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [7:0]  brightness_ff;
   logic [15:0] high_duty_ff;
   logic [15:0] low_duty_ff;
   logic [1:0]  reg_index;
   logic        csr_write;

   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   logic     q_head_valid;
   item_type q_head_item;

   assign pready = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
         high_duty_ff <= HIGH_DUTY_RESET;
         low_duty_ff <= LOW_DUTY_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_BRIGHTNESS: brightness_ff <= pwdata[7:0];
            REG_HIGH_DUTY: high_duty_ff <= pwdata[15:0];
            REG_LOW_DUTY: low_duty_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_BRIGHTNESS: prdata = {24'd0, brightness_ff};
         REG_HIGH_DUTY: prdata = {16'd0, high_duty_ff};
         REG_LOW_DUTY: prdata = {16'd0, low_duty_ff};
         default: prdata = 32'd0;
      endcase
   end

   rlpde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .brightness (brightness_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   rlpde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   rlpde_back #(
      .RESET_SLOTS (RESET_SLOTS),
      .DUTY_WIDTH  (DUTY_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_item   (q_head_item),
      .pop         (q_pop),
      .high_duty   (high_duty_ff),
      .low_duty    (low_duty_ff),
      .rsp_valid   (rsp_valid),
      .rsp_duty    (rsp_duty),
      .rsp_run_end (rsp_run_end)
   );

endmodule
